// File: src/vpp_pkg.sv
// Package with shared types, constants and helper functions of the vertex projection block.
`default_nettype none
package vpp_pkg;

  localparam int unsigned QW   = 32;
  localparam int unsigned REMW = 66;
  localparam int unsigned DENW = 33;

  localparam logic [QW-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [QW-1:0] Q_MIN = 32'h8000_0000;

  localparam logic signed [QW-1:0] REF_Z_RST   = 32'sd98304;
  localparam logic signed [QW-1:0] PLANE_Z_RST = 32'sd78643;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_REF_X   = 3'd1,
    REG_REF_Y   = 3'd2,
    REG_REF_Z   = 3'd3,
    REG_PLANE_Z = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic                   parallel;
    logic signed [QW-1:0]   ref_x;
    logic signed [QW-1:0]   ref_y;
    logic signed [QW-1:0]   ref_z;
    logic signed [QW-1:0]   plane_z;
  } cfg_t;

  // One coordinate on its way through the divider chain.
  typedef struct packed {
    logic            byp;
    logic            neg;
    logic [REMW-1:0] rem;
    logic [QW-1:0]   q;
  } lane_t;

  typedef struct packed {
    lane_t           x;
    lane_t           y;
    logic [DENW-1:0] md;
    logic            fault;
  } cell_t;

  // Sets a lane up for division; results known in advance are marked bypassed.
  function automatic lane_t lane_init(logic signed [REMW-1:0] num, logic [DENW-1:0] md,
                                      logic dneg, logic dzero, logic par,
                                      logic [QW-1:0] v);
    lane_t           l;
    logic            nn;
    logic [REMW-1:0] mn;
    nn     = num[REMW-1];
    mn     = nn ? REMW'(-num) : REMW'(num);
    l.rem  = mn;
    l.neg  = nn ^ dneg;
    l.byp  = 1'b0;
    l.q    = '0;
    if (par) begin
      l.byp = 1'b1;
      l.q   = v;
    end else if (dzero) begin
      l.byp = 1'b1;
      l.q   = nn ? Q_MIN : Q_MAX;
    end else if (mn[REMW-1:QW] >= {1'b0, md}) begin
      l.byp = 1'b1;
      l.q   = l.neg ? Q_MIN : Q_MAX;
    end
    return l;
  endfunction

  // Passes a bypassed result through; else applies the sign to the quotient magnitude and saturates.
  function automatic logic [QW-1:0] lane_result(lane_t l);
    logic [QW-1:0] r;
    if (l.byp) begin
      r = l.q;
    end else if (l.neg) begin
      r = (l.q > Q_MIN) ? Q_MIN : QW'(-l.q);
    end else begin
      r = l.q[QW-1] ? Q_MAX : l.q;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/vpp_if.sv
// Stream interfaces for vertices in and projected vertices out.
`default_nettype none
interface vpp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] vx;
  logic [31:0] vy;
  logic [31:0] vz;
  modport source (output valid, vx, vy, vz, input ready);
  modport sink   (input valid, vx, vy, vz, output ready);
endinterface

interface vpp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic        div_fault;
  modport source (output valid, out_x, out_y, out_z, div_fault, input ready);
  modport sink   (input valid, out_x, out_y, out_z, div_fault, output ready);
endinterface
`default_nettype wire

// File: src/vpp_front.sv
// Front stages: numerator products, then sign, magnitude and early results.
`default_nettype none
module vpp_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire vpp_pkg::cfg_t       cfg_i,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire logic [31:0]         vx_i,
  input  wire logic [31:0]         vy_i,
  input  wire logic [31:0]         vz_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output vpp_pkg::cell_t           data_o
);

  logic signed [32:0] dzp, dpv, den_d;
  logic signed [64:0] pax_d, pbx_d, pay_d, pby_d;
  logic signed [64:0] pax_q, pbx_q, pay_q, pby_q;
  logic signed [32:0] den_q;
  logic [31:0]        vx_q, vy_q;
  logic               va_q, vb_q, rdy_a, rdy_b;
  logic signed [65:0] numx, numy;
  logic [32:0]        md;
  logic               dzero;
  vpp_pkg::cell_t     cell_d, cell_q;

  assign dzp   = 33'(cfg_i.ref_z) - 33'(cfg_i.plane_z);
  assign dpv   = 33'(cfg_i.plane_z) - 33'($signed(vz_i));
  assign den_d = 33'(cfg_i.ref_z) - 33'($signed(vz_i));
  assign pax_d = $signed(vx_i) * dzp;
  assign pbx_d = cfg_i.ref_x * dpv;
  assign pay_d = $signed(vy_i) * dzp;
  assign pby_d = cfg_i.ref_y * dpv;

  assign rdy_b   = !vb_q || ready_i;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      pax_q <= pax_d;
      pbx_q <= pbx_d;
      pay_q <= pay_d;
      pby_q <= pby_d;
      den_q <= den_d;
      vx_q  <= vx_i;
      vy_q  <= vy_i;
    end
    if (rdy_b && va_q) cell_q <= cell_d;
  end

  assign numx  = 66'(pax_q) + 66'(pbx_q);
  assign numy  = 66'(pay_q) + 66'(pby_q);
  assign md    = den_q[32] ? 33'(-den_q) : 33'(den_q);
  assign dzero = (den_q == '0);

  always_comb begin
    cell_d.md    = md;
    cell_d.fault = !cfg_i.parallel && dzero;
    cell_d.x     = vpp_pkg::lane_init(numx, md, den_q[32], dzero, cfg_i.parallel, vx_q);
    cell_d.y     = vpp_pkg::lane_init(numy, md, den_q[32], dzero, cfg_i.parallel, vy_q);
  end

  assign valid_o = vb_q;
  assign data_o  = cell_q;

endmodule
`default_nettype wire

// File: src/vpp_div_cell.sv
// One restoring-division cell: settles one quotient bit of both lanes.
`default_nettype none
module vpp_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire vpp_pkg::cell_t data_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output vpp_pkg::cell_t      data_o
);

  logic               valid_q;
  vpp_pkg::cell_t     data_q, data_d;
  logic [vpp_pkg::REMW-1:0] sub;

  assign sub = vpp_pkg::REMW'(data_i.md) << BIT;

  always_comb begin
    data_d = data_i;
    if (!data_i.x.byp && data_i.x.rem >= sub) begin
      data_d.x.rem    = data_i.x.rem - sub;
      data_d.x.q[BIT] = 1'b1;
    end
    if (!data_i.y.byp && data_i.y.rem >= sub) begin
      data_d.y.rem    = data_i.y.rem - sub;
      data_d.y.q[BIT] = 1'b1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// File: src/vertex_perspective_projection.sv
// Top level of the vertex perspective projection block.
`default_nettype none
// Projects one Q16.16 vertex per cycle, unless the output stalls, onto the plane
// z = plane_z through the reference point, or flattens it onto that plane in
// parallel mode. A vertex passes two front stages (the four numerator products,
// then sign, magnitude and the early decision on faults and overflow), a chain of
// 32 division cells that each settle one quotient bit for x and y together, and
// an output register; one vertex is accepted per cycle while the output is not
// stalled. Every stage holds its item independently, so input transfers continue
// while a finished result waits, until the chain is full. The user must write
// configuration through the plain write port only while no vertex is in flight;
// the block does not enforce this. Writes to an index past plane_z are dropped.
// Outside parallel mode a zero denominator raises div_fault and gives the
// saturated value in the numerator's direction.
module vertex_perspective_projection (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  vpp_in_if.sink           vtx_i,
  vpp_out_if.source        prj_o
);

  localparam int unsigned NCELL = vpp_pkg::QW;

  vpp_pkg::cfg_t  cfg_q;
  vpp_pkg::cell_t chain_data [NCELL+1];
  logic           chain_valid [NCELL+1];
  logic           chain_ready [NCELL+1];

  logic        ovalid_q, out_rdy;
  logic [31:0] ox_q, oy_q;
  logic        ofault_q;

  // Configuration registers; the write index is decoded by name.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.parallel <= 1'b0;
      cfg_q.ref_x    <= '0;
      cfg_q.ref_y    <= '0;
      cfg_q.ref_z    <= vpp_pkg::REF_Z_RST;
      cfg_q.plane_z  <= vpp_pkg::PLANE_Z_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vpp_pkg::REG_MODE:    cfg_q.parallel <= cfg_wdata_i[0];
        vpp_pkg::REG_REF_X:   cfg_q.ref_x    <= $signed(cfg_wdata_i);
        vpp_pkg::REG_REF_Y:   cfg_q.ref_y    <= $signed(cfg_wdata_i);
        vpp_pkg::REG_REF_Z:   cfg_q.ref_z    <= $signed(cfg_wdata_i);
        vpp_pkg::REG_PLANE_Z: cfg_q.plane_z  <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  vpp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (vtx_i.valid),
    .ready_o (vtx_i.ready),
    .vx_i    (vtx_i.vx),
    .vy_i    (vtx_i.vy),
    .vz_i    (vtx_i.vz),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .data_o  (chain_data[0])
  );

  // Cell k settles quotient bit 31-k; the most significant bit goes first.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    vpp_div_cell #(.BIT(NCELL-1-k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  // Output register: sign and saturation are applied on the way in.
  assign out_rdy            = !ovalid_q || prj_o.ready;
  assign chain_ready[NCELL] = out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (out_rdy) begin
      ovalid_q <= chain_valid[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && chain_valid[NCELL]) begin
      ox_q     <= vpp_pkg::lane_result(chain_data[NCELL].x);
      oy_q     <= vpp_pkg::lane_result(chain_data[NCELL].y);
      ofault_q <= chain_data[NCELL].fault;
    end
  end

  // The user must keep the plane height static while vertices are in flight; the block does not enforce this.
  assign prj_o.valid     = ovalid_q;
  assign prj_o.out_x     = ox_q;
  assign prj_o.out_y     = oy_q;
  assign prj_o.out_z     = cfg_q.plane_z;
  assign prj_o.div_fault = ofault_q;

endmodule
`default_nettype wire

// File: src/vpp_checker.sv
// Port-level checks of the vertex projection block and their binding.
`default_nettype none
module vpp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        ready_i,
  input wire logic [31:0] x_i,
  input wire logic [31:0] y_i,
  input wire logic        fault_i,
  input wire logic        cfg_we_i,
  input wire logic [2:0]  cfg_idx_i,
  input wire logic [31:0] cfg_wdata_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(x_i) && $stable(y_i))
    else $error("result changed while stalled");

  a_fault_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && fault_i |-> (x_i == 32'h8000_0000 || x_i == 32'h7fff_ffff))
    else $error("faulted x not saturated");

  a_fault_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && fault_i |-> (y_i == 32'h8000_0000 || y_i == 32'h7fff_ffff))
    else $error("faulted y not saturated");

  a_par: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == vpp_pkg::REG_MODE && cfg_wdata_i[0] |=> ##36
      !(valid_i && fault_i))
    else $error("fault raised in parallel mode");

endmodule

bind vertex_perspective_projection vpp_checker u_vpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .valid_i     (prj_o.valid),
  .ready_i     (prj_o.ready),
  .x_i         (prj_o.out_x),
  .y_i         (prj_o.out_y),
  .fault_i     (prj_o.div_fault),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_wdata_i (cfg_wdata_i)
);
`default_nettype wire
